// ===== src/sha1md_pkg.sv =====
package sha1md_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds    = 80;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] H0Init = 32'h67452301;
  localparam logic [31:0] H1Init = 32'hEFCDAB89;
  localparam logic [31:0] H2Init = 32'h98BADCFE;
  localparam logic [31:0] H3Init = 32'h10325476;
  localparam logic [31:0] H4Init = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef struct packed {
    logic [31:0] data;
    logic        msg_last;
  } word_beat_t;

  typedef logic [4:0][31:0] chain_t;

  function automatic chain_t chain_init();
    chain_t h;
    h[0] = H0Init;
    h[1] = H1Init;
    h[2] = H2Init;
    h[3] = H3Init;
    h[4] = H4Init;
    return h;
  endfunction

  function automatic logic [31:0] rotl1(input logic [31:0] v);
    return {v[30:0], v[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] v);
    return {v[26:0], v[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] v);
    return {v[1:0], v[31:2]};
  endfunction

endpackage

// ===== src/sha1md_front.sv =====
module sha1md_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             msg_byte_i,
  input  logic                   byte_present_i,
  input  logic                   message_end_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   fifo_full_i,
  output logic                   push_o,
  output sha1md_pkg::word_beat_t push_beat_o
);
  import sha1md_pkg::*;

  logic [23:0] word_q, word_d;
  logic [1:0]  byte_cnt_q, byte_cnt_d;
  logic [3:0]  word_cnt_q, word_cnt_d;
  logic [63:0] bit_len_q, bit_len_d;
  logic        pad_q, pad_d;
  logic        first_q, first_d;
  logic        len_ok_q, len_ok_d;
  logic        accept;
  logic [31:0] pad_word;

  assign in_stall_o = pad_q | fifo_full_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    case (byte_cnt_q)
      2'd0:    pad_word = {PadByte, 24'h0};
      2'd1:    pad_word = {word_q[7:0], PadByte, 16'h0};
      2'd2:    pad_word = {word_q[15:0], PadByte, 8'h0};
      default: pad_word = {word_q[23:0], PadByte};
    endcase
  end

  always_comb begin
    word_d      = word_q;
    byte_cnt_d  = byte_cnt_q;
    word_cnt_d  = word_cnt_q;
    bit_len_d   = bit_len_q;
    pad_d       = pad_q;
    first_d     = first_q;
    len_ok_d    = len_ok_q;
    push_o      = 1'b0;
    push_beat_o = '{data: 32'h0, msg_last: 1'b0};

    if (accept) begin
      if (byte_present_i) begin
        word_d     = {word_q[15:0], msg_byte_i};
        byte_cnt_d = byte_cnt_q + 2'd1;
        bit_len_d  = bit_len_q + 64'd8;
        if (byte_cnt_q == 2'd3) begin
          push_o      = 1'b1;
          push_beat_o = '{data: {word_q, msg_byte_i}, msg_last: 1'b0};
          word_cnt_d  = word_cnt_q + 4'd1;
        end
      end
      if (message_end_i) begin
        pad_d    = 1'b1;
        first_d  = 1'b1;
        len_ok_d = 1'b0;
      end
    end else if (pad_q && !fifo_full_i) begin
      push_o     = 1'b1;
      word_cnt_d = word_cnt_q + 4'd1;
      first_d    = 1'b0;
      byte_cnt_d = 2'd0;
      if (first_q) begin
        push_beat_o.data = pad_word;
        len_ok_d = (word_cnt_q <= 4'd13) || (word_cnt_q == 4'd15);
      end else if (len_ok_q && word_cnt_q == 4'd14) begin
        push_beat_o.data = bit_len_q[63:32];
      end else if (len_ok_q && word_cnt_q == 4'd15) begin
        push_beat_o = '{data: bit_len_q[31:0], msg_last: 1'b1};
        // message done: return to idle
        pad_d     = 1'b0;
        len_ok_d  = 1'b0;
        bit_len_d = 64'h0;
      end else if (word_cnt_q == 4'd15) begin
        len_ok_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= 2'd0;
      word_cnt_q <= 4'd0;
      bit_len_q  <= 64'h0;
      pad_q      <= 1'b0;
      first_q    <= 1'b0;
      len_ok_q   <= 1'b0;
    end else begin
      byte_cnt_q <= byte_cnt_d;
      word_cnt_q <= word_cnt_d;
      bit_len_q  <= bit_len_d;
      pad_q      <= pad_d;
      first_q    <= first_d;
      len_ok_q   <= len_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

// ===== src/sha1md_fifo.sv =====
module sha1md_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  sha1md_pkg::word_beat_t push_beat_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output sha1md_pkg::word_beat_t pop_beat_o,
  output logic                   empty_o
);
  import sha1md_pkg::*;

  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  word_beat_t            mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       cnt_q;

  assign full_o     = (cnt_q == CntW'(FifoDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_beat_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== src/sha1md_core.sv =====
module sha1md_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fifo_empty_i,
  input  sha1md_pkg::word_beat_t pop_beat_i,
  output logic                   pop_o,
  output logic [31:0]            digest_word_o,
  output logic                   digest_last_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i
);
  import sha1md_pkg::*;

  localparam logic [1:0] StLoad  = 2'd0;
  localparam logic [1:0] StRound = 2'd1;
  localparam logic [1:0] StAdd   = 2'd2;
  localparam logic [1:0] StOut   = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [31:0] win_q [BlockWords];
  logic [31:0] win_d [BlockWords];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] a_d, b_d, c_d, d_d, e_d;
  chain_t      h_q, h_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [3:0]  ld_cnt_q, ld_cnt_d;
  logic [2:0]  idx_q, idx_d;
  logic        msg_end_q, msg_end_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_word_q, out_word_d;
  logic        out_last_q, out_last_d;
  logic        out_free;
  logic [31:0] w, f, k, sum;

  assign out_free      = ~out_valid_q | ~out_stall_i;
  assign out_valid_o   = out_valid_q;
  assign digest_word_o = out_word_q;
  assign digest_last_o = out_last_q;
  assign pop_o         = (state_q == StLoad) && !fifo_empty_i;

  always_comb begin
    if (rnd_q < 7'd16) begin
      w = win_q[0];
    end else begin
      w = rotl1(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0]);
    end
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = K0;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = K1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K3;
    end
    sum = rotl5(a_q) + f + e_q + k + w;
  end

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    d_d         = d_q;
    e_d         = e_q;
    h_d         = h_q;
    rnd_d       = rnd_q;
    ld_cnt_d    = ld_cnt_q;
    idx_d       = idx_q;
    msg_end_d   = msg_end_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_word_d  = out_word_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      StLoad: begin
        if (pop_o) begin
          for (int i = 0; i < BlockWords - 1; i++) begin
            win_d[i] = win_q[i+1];
          end
          win_d[BlockWords-1] = pop_beat_i.data;
          ld_cnt_d = ld_cnt_q + 4'd1;
          if (ld_cnt_q == 4'd15) begin
            msg_end_d = pop_beat_i.msg_last;
            a_d       = h_q[0];
            b_d       = h_q[1];
            c_d       = h_q[2];
            d_d       = h_q[3];
            e_d       = h_q[4];
            rnd_d     = 7'd0;
            state_d   = StRound;
          end
        end
      end
      StRound: begin
        for (int i = 0; i < BlockWords - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[BlockWords-1] = w;
        e_d   = d_q;
        d_d   = c_q;
        c_d   = rotl30(b_q);
        b_d   = a_q;
        a_d   = sum;
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'(Rounds - 1)) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        h_d[0] = h_q[0] + a_q;
        h_d[1] = h_q[1] + b_q;
        h_d[2] = h_q[2] + c_q;
        h_d[3] = h_q[3] + d_q;
        h_d[4] = h_q[4] + e_q;
        idx_d  = 3'd0;
        state_d = msg_end_q ? StOut : StLoad;
      end
      StOut: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = h_q[idx_q];
          out_last_d  = (idx_q == 3'd4);
          idx_d       = idx_q + 3'd1;
          if (idx_q == 3'd4) begin
            h_d     = chain_init();
            state_d = StLoad;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      h_q         <= chain_init();
      rnd_q       <= 7'd0;
      ld_cnt_q    <= 4'd0;
      idx_q       <= 3'd0;
      msg_end_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      h_q         <= h_d;
      rnd_q       <= rnd_d;
      ld_cnt_q    <= ld_cnt_d;
      idx_q       <= idx_d;
      msg_end_q   <= msg_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q      <= win_d;
    a_q        <= a_d;
    b_q        <= b_d;
    c_q        <= c_d;
    d_q        <= d_d;
    e_q        <= e_d;
    out_word_q <= out_word_d;
    out_last_q <= out_last_d;
  end

endmodule

// ===== src/sha1_message_digest.sv =====
// SHA-1 message digest over a byte stream.
// Input channel: one beat carries msg_byte_i, byte_present_i and message_end_i.
// A beat with byte_present_i adds a byte; a beat with message_end_i closes the
// message (with or without a byte of its own).
// Output channel: five beats of digest_word_o, H0 first; digest_last_o marks
// the fifth.
// The front packs bytes into 32-bit words and appends padding and the 64-bit
// bit length, one word per cycle while the queue has room, into a four-word
// queue. The back loads 16 words, runs 80 rounds at one round per cycle and
// adds into the chain value. Loading does not overlap the rounds, so while
// streaming only four words wait in the queue and the rest arrive one per four
// bytes. Bytes are taken one per cycle until the queue fills; padding stalls
// the input, longest when the pad words run into a block of their own.
// After the last block the five digest words leave one per cycle, while the
// output is not stalled, through an output register. A stalled output holds
// its beat and the back waits.
// Reset clears the chain value to the initial hash values and empties the
// queue and all counters; no message is in progress afterward.
module sha1_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  msg_byte_i,
  input  logic        byte_present_i,
  input  logic        message_end_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic [31:0] digest_word_o,
  output logic        digest_last_o,
  output logic        out_valid_o,
  input  logic        out_stall_i
);
  import sha1md_pkg::*;

  word_beat_t push_beat, pop_beat;
  logic       push, pop, fifo_full, fifo_empty;

  sha1md_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .msg_byte_i     (msg_byte_i),
    .byte_present_i (byte_present_i),
    .message_end_i  (message_end_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .fifo_full_i    (fifo_full),
    .push_o         (push),
    .push_beat_o    (push_beat)
  );

  sha1md_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_beat_i (push_beat),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .pop_beat_o  (pop_beat),
    .empty_o     (fifo_empty)
  );

  sha1md_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_empty_i  (fifo_empty),
    .pop_beat_i    (pop_beat),
    .pop_o         (pop),
    .digest_word_o (digest_word_o),
    .digest_last_o (digest_last_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i)
  );

endmodule
